// File: hw/rtl/lam_pkg.sv
package lam_pkg;

    typedef logic signed [31:0] q30_t;
    typedef logic signed [63:0] wide_t;

    typedef struct packed {
        logic signed [31:0] from_x;
        logic signed [31:0] from_y;
        logic signed [31:0] from_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
    } lam_req_t;

    typedef struct packed {
        logic signed [31:0] right_x;
        logic signed [31:0] right_y;
        logic signed [31:0] right_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
        logic signed [31:0] fwd_x;
        logic signed [31:0] fwd_y;
        logic signed [31:0] fwd_z;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
    } lam_rsp_t;

    localparam int NRM_LEAD_POS = 29;
    localparam int NRM_SQRT_STEPS = 2;
    localparam int NRM_SQRT_STAGES = 32 / NRM_SQRT_STEPS;
    localparam int NRM_DIV_STEPS = 2;
    localparam int NRM_DIV_STAGES = 32 / NRM_DIV_STEPS;
    localparam int NRM_LATENCY = 5 + NRM_SQRT_STAGES + 1 + NRM_DIV_STAGES + 1;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

endpackage

// File: hw/rtl/lam_norm.sv
module lam_norm import lam_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  wide_t vec [3],
    output logic  out_valid,
    output q30_t  unit [3]
);

    typedef struct packed {
        logic [2:0][29:0] mag;
        logic [2:0]       neg;
        logic             zero;
    } side_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } sign_t;

    logic [NRM_LATENCY-1:0] vld_reg;

    logic [63:0] mag1_reg [3];
    logic [2:0]  neg1_reg;

    logic [63:0] mag2_reg [3];
    logic [2:0]  neg2_reg;
    logic [5:0]  lead2_reg;
    logic        zero2_reg;
    logic [63:0] orv;
    logic [5:0]  lead_next;

    side_t       side3_reg;
    side_t       side3_next;

    side_t       side4_reg;
    logic [59:0] sq4_reg [3];

    side_t       side5_reg;
    logic [61:0] sum5_reg;

    logic [63:0] sqs_reg [NRM_SQRT_STAGES];
    logic [63:0] sqr_reg [NRM_SQRT_STAGES];
    side_t       sqside_reg [NRM_SQRT_STAGES];

    logic [31:0] prerem_reg [3];
    logic [31:0] prenum_reg [3];
    logic [30:0] prelen_reg;
    sign_t       presign_reg;
    logic [30:0] len_w;

    logic [2:0][31:0] dvrem_reg [NRM_DIV_STAGES];
    logic [2:0][31:0] dvnum_reg [NRM_DIV_STAGES];
    logic [2:0][31:0] dvq_reg [NRM_DIV_STAGES];
    logic [30:0]      dvlen_reg [NRM_DIV_STAGES];
    sign_t            dvsign_reg [NRM_DIV_STAGES];

    q30_t unit_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NRM_LATENCY-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg1_reg[i] <= vec[i][63];
            mag1_reg[i] <= vec[i][63] ? (64'd0 - vec[i]) : vec[i];
        end
    end

    always_comb
    begin
        orv = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];
        lead_next = '0;
        for (int b = 0; b < 64; b++)
        begin
            if (orv[b])
            begin
                lead_next = 6'(b);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag2_reg  <= mag1_reg;
        neg2_reg  <= neg1_reg;
        lead2_reg <= lead_next;
        zero2_reg <= (orv == '0);
    end

    always_comb
    begin
        logic [63:0] m;
        side3_next.neg  = neg2_reg;
        side3_next.zero = zero2_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (lead2_reg > 6'(NRM_LEAD_POS))
            begin
                m = mag2_reg[i] >> (lead2_reg - 6'(NRM_LEAD_POS));
            end
            else
            begin
                m = mag2_reg[i] << (6'(NRM_LEAD_POS) - lead2_reg);
            end
            side3_next.mag[i] = m[29:0];
        end
    end

    always_ff @(posedge clk)
    begin
        side3_reg <= side3_next;
        side4_reg <= side3_reg;
        for (int i = 0; i < 3; i++)
        begin
            sq4_reg[i] <= 60'(side3_reg.mag[i]) * 60'(side3_reg.mag[i]);
        end
        side5_reg <= side4_reg;
        sum5_reg  <= 62'(sq4_reg[0]) + 62'(sq4_reg[1]) + 62'(sq4_reg[2]);
    end

    for (genvar g = 0; g < NRM_SQRT_STAGES; g++)
    begin : g_sqrt
        logic [63:0] s_in;
        logic [63:0] r_in;
        side_t       side_in;
        logic [63:0] s_c;
        logic [63:0] r_c;

        if (g == 0)
        begin : g_first
            assign s_in    = {2'b00, sum5_reg};
            assign r_in    = '0;
            assign side_in = side5_reg;
        end
        else
        begin : g_rest
            assign s_in    = sqs_reg[g-1];
            assign r_in    = sqr_reg[g-1];
            assign side_in = sqside_reg[g-1];
        end

        always_comb
        begin
            logic [63:0] bitv;
            s_c = s_in;
            r_c = r_in;
            for (int j = 0; j < NRM_SQRT_STEPS; j++)
            begin
                bitv = 64'd1 << (62 - 2 * (g * NRM_SQRT_STEPS + j));
                if (s_c >= r_c + bitv)
                begin
                    s_c = s_c - (r_c + bitv);
                    r_c = (r_c >> 1) + bitv;
                end
                else
                begin
                    r_c = r_c >> 1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            sqs_reg[g]    <= s_c;
            sqr_reg[g]    <= r_c;
            sqside_reg[g] <= side_in;
        end
    end

    assign len_w = sqr_reg[NRM_SQRT_STAGES-1][30:0];

    always_ff @(posedge clk)
    begin
        logic [63:0] n;
        for (int i = 0; i < 3; i++)
        begin
            n = {4'b0, sqside_reg[NRM_SQRT_STAGES-1].mag[i], 30'b0} + 64'(len_w >> 1);
            prerem_reg[i] <= n[63:32];
            prenum_reg[i] <= n[31:0];
        end
        prelen_reg       <= len_w;
        presign_reg.neg  <= sqside_reg[NRM_SQRT_STAGES-1].neg;
        presign_reg.zero <= sqside_reg[NRM_SQRT_STAGES-1].zero;
    end

    for (genvar g = 0; g < NRM_DIV_STAGES; g++)
    begin : g_div
        logic [2:0][31:0] rem_in;
        logic [2:0][31:0] num_in;
        logic [2:0][31:0] q_in;
        logic [30:0]      len_in;
        sign_t            sign_in;
        logic [2:0][31:0] rem_c;
        logic [2:0][31:0] num_c;
        logic [2:0][31:0] q_c;

        if (g == 0)
        begin : g_first
            assign rem_in  = {prerem_reg[2], prerem_reg[1], prerem_reg[0]};
            assign num_in  = {prenum_reg[2], prenum_reg[1], prenum_reg[0]};
            assign q_in    = '0;
            assign len_in  = prelen_reg;
            assign sign_in = presign_reg;
        end
        else
        begin : g_rest
            assign rem_in  = dvrem_reg[g-1];
            assign num_in  = dvnum_reg[g-1];
            assign q_in    = dvq_reg[g-1];
            assign len_in  = dvlen_reg[g-1];
            assign sign_in = dvsign_reg[g-1];
        end

        always_comb
        begin
            logic [31:0] t;
            rem_c = rem_in;
            num_c = num_in;
            q_c   = q_in;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < NRM_DIV_STEPS; j++)
                begin
                    t = {rem_c[i][30:0], num_c[i][31]};
                    num_c[i] = {num_c[i][30:0], 1'b0};
                    if (t >= {1'b0, len_in})
                    begin
                        rem_c[i] = t - {1'b0, len_in};
                        q_c[i]   = {q_c[i][30:0], 1'b1};
                    end
                    else
                    begin
                        rem_c[i] = t;
                        q_c[i]   = {q_c[i][30:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            dvrem_reg[g]  <= rem_c;
            dvnum_reg[g]  <= num_c;
            dvq_reg[g]    <= q_c;
            dvlen_reg[g]  <= len_in;
            dvsign_reg[g] <= sign_in;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [31:0] qc;
        for (int i = 0; i < 3; i++)
        begin
            qc = dvq_reg[NRM_DIV_STAGES-1][i];
            if (qc > ONE_Q30)
            begin
                qc = ONE_Q30;
            end
            if (dvsign_reg[NRM_DIV_STAGES-1].zero)
            begin
                unit_reg[i] <= '0;
            end
            else if (dvsign_reg[NRM_DIV_STAGES-1].neg[i])
            begin
                unit_reg[i] <= 32'd0 - qc;
            end
            else
            begin
                unit_reg[i] <= qc;
            end
        end
    end

    assign out_valid = vld_reg[NRM_LATENCY-1];
    assign unit      = unit_reg;

endmodule

// File: hw/rtl/look_at_matrix_top.sv
// Builds the camera-to-world rows of a look-at camera from a camera position and a target,
// both signed Q16.16. A request is taken on any cycle with start high; busy is always low,
// so one request per cycle is sustained. Each result appears on rsp for one cycle with
// done high, in request order; the receiver cannot stall and must take it then. Each
// result passes through two normalization pipelines in series, each with a 32-step
// square root and 32-step divisions at two steps per stage. Unit vectors are Q1.30
// and a zero-length vector gives all zeros, so a camera on its target, or one looking
// along the z axis, yields zero right and up rows.
module look_at_matrix_top import lam_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  lam_req_t req,
    output logic     done,
    output lam_rsp_t rsp
);

    logic        v1_reg;
    wide_t       d_reg [3];
    logic [95:0] from1_reg;

    logic        fv;
    q30_t        f [3];
    logic [95:0] froma_reg [NRM_LATENCY];

    logic        m1v_reg;
    wide_t       p20_reg;
    wide_t       p21_reg;
    wide_t       p00_reg;
    wide_t       p11_reg;
    wide_t       rr1_reg [3];
    logic [191:0] pass1_reg;

    logic        m2v_reg;
    wide_t       ur_reg [3];
    wide_t       rr2_reg [3];
    logic [191:0] pass2_reg;

    logic        rv;
    logic        uv;
    q30_t        r [3];
    q30_t        u [3];
    logic [191:0] passb_reg [NRM_LATENCY];

    logic        done_reg;
    lam_rsp_t    rsp_reg;
    lam_rsp_t    rsp_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            m1v_reg  <= 1'b0;
            m2v_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            m1v_reg  <= fv;
            m2v_reg  <= m1v_reg;
            done_reg <= rv;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg[0]  <= {{32{req.from_x[31]}}, req.from_x} - {{32{req.target_x[31]}}, req.target_x};
        d_reg[1]  <= {{32{req.from_y[31]}}, req.from_y} - {{32{req.target_y[31]}}, req.target_y};
        d_reg[2]  <= {{32{req.from_z[31]}}, req.from_z} - {{32{req.target_z[31]}}, req.target_z};
        from1_reg <= {req.from_x, req.from_y, req.from_z};
    end

    lam_norm u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1_reg),
        .vec       (d_reg),
        .out_valid (fv),
        .unit      (f)
    );

    always_ff @(posedge clk)
    begin
        froma_reg[0] <= from1_reg;
        for (int k = 1; k < NRM_LATENCY; k++)
        begin
            froma_reg[k] <= froma_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        p20_reg    <= 64'(f[2]) * 64'(f[0]);
        p21_reg    <= 64'(f[2]) * 64'(f[1]);
        p00_reg    <= 64'(f[0]) * 64'(f[0]);
        p11_reg    <= 64'(f[1]) * 64'(f[1]);
        rr1_reg[0] <= 64'd0 - 64'(f[1]);
        rr1_reg[1] <= 64'(f[0]);
        rr1_reg[2] <= '0;
        pass1_reg  <= {f[0], f[1], f[2], froma_reg[NRM_LATENCY-1]};

        ur_reg[0]  <= 64'd0 - p20_reg;
        ur_reg[1]  <= 64'd0 - p21_reg;
        ur_reg[2]  <= p00_reg + p11_reg;
        rr2_reg    <= rr1_reg;
        pass2_reg  <= pass1_reg;
    end

    lam_norm u_norm_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m2v_reg),
        .vec       (rr2_reg),
        .out_valid (rv),
        .unit      (r)
    );

    lam_norm u_norm_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m2v_reg),
        .vec       (ur_reg),
        .out_valid (uv),
        .unit      (u)
    );

    always_ff @(posedge clk)
    begin
        passb_reg[0] <= pass2_reg;
        for (int k = 1; k < NRM_LATENCY; k++)
        begin
            passb_reg[k] <= passb_reg[k-1];
        end
    end

    always_comb
    begin
        rsp_next.right_x = r[0];
        rsp_next.right_y = r[1];
        rsp_next.right_z = r[2];
        rsp_next.up_x    = u[0];
        rsp_next.up_y    = u[1];
        rsp_next.up_z    = u[2];
        rsp_next.fwd_x   = passb_reg[NRM_LATENCY-1][191:160];
        rsp_next.fwd_y   = passb_reg[NRM_LATENCY-1][159:128];
        rsp_next.fwd_z   = passb_reg[NRM_LATENCY-1][127:96];
        rsp_next.trans_x = passb_reg[NRM_LATENCY-1][95:64];
        rsp_next.trans_y = passb_reg[NRM_LATENCY-1][63:32];
        rsp_next.trans_z = passb_reg[NRM_LATENCY-1][31:0];
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef NO_ASSERTIONS
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n) rv == uv)
        else $error("right and up pipelines out of step");

    a_right_z_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> rsp.right_z == 32'sd0)
        else $error("right vector has a z component");

    a_zero_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.fwd_x == 32'sd0 && rsp.fwd_y == 32'sd0 && rsp.fwd_z == 32'sd0)
        |-> (rsp.right_x == 32'sd0 && rsp.right_y == 32'sd0
            && rsp.up_x == 32'sd0 && rsp.up_y == 32'sd0 && rsp.up_z == 32'sd0))
        else $error("zero forward vector with nonzero right or up");
`endif

endmodule
